// File: rtl/bat_pkg.sv
// ----------------------------------------------------------------------------
// bat_pkg
// Types, constants and helpers shared by the box affine transform unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bat_pkg;

	localparam int CoordBits         = 24;
	localparam int HalfBits          = CoordBits - 1;
	localparam int CoefBits          = 16;
	localparam int RowBits           = 3 * CoefBits;
	localparam int CoefFracBitsDef   = 12;
	localparam int ProdBits          = CoefBits + CoordBits;
	localparam int SumBits           = ProdBits + 2;
	localparam int CfgIndexBits      = 3;

	localparam logic [RowBits-1:0] Row0Reset = RowBits'(64'd4096 << 32);
	localparam logic [RowBits-1:0] Row1Reset = RowBits'(64'd4096);
	localparam logic [RowBits-1:0] Row2Reset = RowBits'(64'd4096);

	typedef enum logic [CfgIndexBits-1:0] {
		REG_ROW0    = 3'd0,
		REG_ROW1    = 3'd1,
		REG_ROW2    = 3'd2,
		REG_SHIFT_X = 3'd3,
		REG_SHIFT_Y = 3'd4,
		REG_SHIFT_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CoordBits-1:0] mid_x;
		logic signed [CoordBits-1:0] mid_y;
		logic signed [CoordBits-1:0] mid_z;
		logic [HalfBits-1:0]         half_x;
		logic [HalfBits-1:0]         half_y;
		logic [HalfBits-1:0]         half_z;
	} box_in_t;

	typedef struct packed {
		logic signed [CoordBits-1:0] new_mid_x;
		logic signed [CoordBits-1:0] new_mid_y;
		logic signed [CoordBits-1:0] new_mid_z;
		logic [HalfBits-1:0]         new_half_x;
		logic [HalfBits-1:0]         new_half_y;
		logic [HalfBits-1:0]         new_half_z;
		logic                        saturated;
	} box_out_t;

	// raw product bits, row-major: [row][col]
	typedef struct packed {
		logic [2:0][2:0][ProdBits-1:0] mid_p;
		logic [2:0][2:0][ProdBits-1:0] half_p;
	} prod_t;

	// row sums with rounding bias already added
	typedef struct packed {
		logic [2:0][SumBits-1:0] mid_sum;
		logic [2:0][SumBits-1:0] half_sum;
	} sum_t;

	// column 0 sits in the top bits of a row
	function automatic logic signed [CoefBits-1:0] coef_at(
		input logic [RowBits-1:0] row,
		input logic [1:0]         col
	);
		logic [RowBits-1:0] sh;
		sh = row >> (CoefBits * (2 - int'(col)));
		return $signed(sh[CoefBits-1:0]);
	endfunction

endpackage

`default_nettype wire

// File: rtl/bat_mul_stage.sv
// ----------------------------------------------------------------------------
// bat_mul_stage
// First stage: nine signed centre products and nine magnitude extent products.
// ----------------------------------------------------------------------------
`default_nettype none

module bat_mul_stage (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [2:0][bat_pkg::RowBits-1:0]    rows,
	input  wire logic                                src_valid,
	output logic                                     src_ready,
	input  wire bat_pkg::box_in_t                    src,
	output logic                                     dst_valid,
	input  wire logic                                dst_ready,
	output bat_pkg::prod_t                           dst
);

	localparam int PW = bat_pkg::ProdBits;
	localparam int CB = bat_pkg::CoordBits;
	localparam int HB = bat_pkg::HalfBits;
	localparam int KB = bat_pkg::CoefBits;

	logic           v_s1;
	bat_pkg::prod_t data_s1;
	bat_pkg::prod_t prod;
	logic [2:0][CB-1:0] mid;
	logic [2:0][HB-1:0] half;

	assign mid  = {src.mid_x, src.mid_y, src.mid_z};
	assign half = {src.half_x, src.half_y, src.half_z};

	always_comb begin
		logic signed [KB-1:0] k;
		logic signed [KB:0]   kx;
		logic [KB:0]          mag;
		logic signed [PW-1:0] ka;
		logic signed [PW-1:0] ma;
		prod = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				k   = bat_pkg::coef_at(rows[2-i], 2'(j));
				kx  = (KB+1)'(k);
				mag = kx[KB] ? (KB+1)'(-kx) : (KB+1)'(kx);
				ka  = PW'(k);
				ma  = PW'($signed(mid[2-j]));
				prod.mid_p[2-i][2-j]  = PW'(ka * ma);
				prod.half_p[2-i][2-j] = PW'(PW'(mag) * PW'(half[2-j]));
			end
		end
	end

	assign src_ready = !v_s1 || dst_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (src_ready) begin
			v_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			data_s1 <= prod;
		end
	end

	assign dst_valid = v_s1;
	assign dst       = data_s1;

endmodule

`default_nettype wire

// File: rtl/bat_sum_stage.sv
// ----------------------------------------------------------------------------
// bat_sum_stage
// Second stage: row sums of the products plus the half-up rounding bias.
// ----------------------------------------------------------------------------
`default_nettype none

module bat_sum_stage #(
	parameter int COEF_FRAC_BITS = bat_pkg::CoefFracBitsDef
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            src_valid,
	output logic                 src_ready,
	input  wire bat_pkg::prod_t  src,
	output logic                 dst_valid,
	input  wire logic            dst_ready,
	output bat_pkg::sum_t        dst
);

	localparam int SW = bat_pkg::SumBits;
	localparam logic [SW-1:0] Bias = SW'(64'd1 << (COEF_FRAC_BITS - 1));

	logic          v_s2;
	bat_pkg::sum_t data_s2;
	bat_pkg::sum_t sum;

	always_comb begin
		logic signed [SW-1:0] c;
		logic [SW-1:0]        e;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			c = $signed(Bias);
			e = Bias;
			for (int j = 0; j < 3; j++) begin
				c = c + SW'($signed(src.mid_p[i][j]));
				e = e + SW'(src.half_p[i][j]);
			end
			sum.mid_sum[i]  = c;
			sum.half_sum[i] = e;
		end
	end

	assign src_ready = !v_s2 || dst_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (src_ready) begin
			v_s2 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			data_s2 <= sum;
		end
	end

	assign dst_valid = v_s2;
	assign dst       = data_s2;

endmodule

`default_nettype wire

// File: rtl/bat_clamp_stage.sv
// ----------------------------------------------------------------------------
// bat_clamp_stage
// Third stage: drop fraction bits, add translation, saturate; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bat_clamp_stage #(
	parameter int COEF_FRAC_BITS = bat_pkg::CoefFracBitsDef
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic [2:0][bat_pkg::CoordBits-1:0]   shift,
	input  wire logic                                 src_valid,
	output logic                                      src_ready,
	input  wire bat_pkg::sum_t                        src,
	output logic                                      dst_valid,
	input  wire logic                                 dst_ready,
	output bat_pkg::box_out_t                         dst
);

	localparam int SW = bat_pkg::SumBits;
	localparam int CB = bat_pkg::CoordBits;
	localparam int HB = bat_pkg::HalfBits;
	localparam logic signed [SW-1:0] CMax = SW'((64'sd1 <<< (CB - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] CMin = -CMax - SW'(1);

	logic              v_s3;
	bat_pkg::box_out_t data_s3;
	bat_pkg::box_out_t res;

	always_comb begin
		logic signed [SW-1:0] c;
		logic [SW-1:0]        e;
		logic [2:0][CB-1:0]   cm;
		logic [2:0][HB-1:0]   hm;
		logic                 sat;
		sat = 1'b0;
		cm  = '0;
		hm  = '0;
		for (int i = 0; i < 3; i++) begin
			c = ($signed(src.mid_sum[i]) >>> COEF_FRAC_BITS) + SW'($signed(shift[i]));
			if (c > CMax) begin
				cm[i] = CB'(CMax);
				sat   = 1'b1;
			end else if (c < CMin) begin
				cm[i] = CB'(CMin);
				sat   = 1'b1;
			end else begin
				cm[i] = CB'(c);
			end
			e = src.half_sum[i] >> COEF_FRAC_BITS;
			if (e > SW'(CMax)) begin
				hm[i] = HB'(CMax);
				sat   = 1'b1;
			end else begin
				hm[i] = HB'(e);
			end
		end
		res.new_mid_x  = $signed(cm[2]);
		res.new_mid_y  = $signed(cm[1]);
		res.new_mid_z  = $signed(cm[0]);
		res.new_half_x = hm[2];
		res.new_half_y = hm[1];
		res.new_half_z = hm[0];
		res.saturated  = sat;
	end

	assign src_ready = !v_s3 || dst_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (src_ready) begin
			v_s3 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			data_s3 <= res;
		end
	end

	assign dst_valid = v_s3;
	assign dst       = data_s3;

endmodule

`default_nettype wire

// File: rtl/box_affine_transform_unit.sv
// ----------------------------------------------------------------------------
// box_affine_transform_unit
// Transforms a centre/half-extent box by a 3x3 matrix and a translation.
//
//   channel  handshake              payload
//   box      box_valid/box_ready    box (bat_pkg::box_in_t)
//   res      res_valid/res_ready    res (bat_pkg::box_out_t)
//   cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Three register stages (multiply, row sum, round/clamp); one item per cycle
// sustained while res_ready is high.
// The last stage is the output register.
// A stall holds every full stage; an empty stage still takes the next item.
// Reset clears stage valid bits and loads the default matrix and translation.
// ----------------------------------------------------------------------------
`default_nettype none

module box_affine_transform_unit #(
	parameter int COEF_FRAC_BITS = bat_pkg::CoefFracBitsDef
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              box_valid,
	output logic                                   box_ready,
	input  wire bat_pkg::box_in_t                  box,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output bat_pkg::box_out_t                      res,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [bat_pkg::CfgIndexBits-1:0]  cfg_index,
	input  wire logic [bat_pkg::RowBits-1:0]       cfg_data
);

	localparam int CB = bat_pkg::CoordBits;

	logic [2:0][bat_pkg::RowBits-1:0] rows_q;
	logic [2:0][CB-1:0]               shift_q;

	logic           p1_valid, p1_ready;
	bat_pkg::prod_t p1;
	logic           p2_valid, p2_ready;
	bat_pkg::sum_t  p2;

	assign cfg_ready = 1'b1;

	// rows_q[2] is row 0, shift_q[2] is x
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= {bat_pkg::Row0Reset, bat_pkg::Row1Reset, bat_pkg::Row2Reset};
			shift_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bat_pkg::REG_ROW0:    rows_q[2]  <= cfg_data;
				bat_pkg::REG_ROW1:    rows_q[1]  <= cfg_data;
				bat_pkg::REG_ROW2:    rows_q[0]  <= cfg_data;
				bat_pkg::REG_SHIFT_X: shift_q[2] <= cfg_data[CB-1:0];
				bat_pkg::REG_SHIFT_Y: shift_q[1] <= cfg_data[CB-1:0];
				bat_pkg::REG_SHIFT_Z: shift_q[0] <= cfg_data[CB-1:0];
				default: ;
			endcase
		end
	end

	bat_mul_stage u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.rows      (rows_q),
		.src_valid (box_valid),
		.src_ready (box_ready),
		.src       (box),
		.dst_valid (p1_valid),
		.dst_ready (p1_ready),
		.dst       (p1)
	);

	bat_sum_stage #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (p1_valid),
		.src_ready (p1_ready),
		.src       (p1),
		.dst_valid (p2_valid),
		.dst_ready (p2_ready),
		.dst       (p2)
	);

	bat_clamp_stage #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (shift_q),
		.src_valid (p2_valid),
		.src_ready (p2_ready),
		.src       (p2),
		.dst_valid (res_valid),
		.dst_ready (res_ready),
		.dst       (res)
	);

endmodule

`default_nettype wire
